FILE: sv/aging_priority_queue_core_defines.svh
// Assertion macros shared by the aging priority queue RTL.
`ifndef AGING_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define AGING_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define APQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define APQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/apq_pkg.sv
// Types and constants of the aging priority queue.
package apq_pkg;

  localparam int PRIO_W   = 8;
  localparam int TASK_W   = 8;
  localparam int STATUS_W = 2;

  typedef logic [PRIO_W-1:0]   apq_prio_t;
  typedef logic [TASK_W-1:0]   apq_task_t;
  typedef logic [STATUS_W-1:0] apq_status_t;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam apq_status_t ST_DONE  = 2'd0;
  localparam apq_status_t ST_FULL  = 2'd1;
  localparam apq_status_t ST_EMPTY = 2'd2;

  localparam apq_prio_t PRIO_MAX = '1;

  typedef struct packed {
    logic      req_type;
    apq_prio_t push_priority;
    apq_task_t push_task_id;
  } apq_item_t;

  typedef struct packed {
    apq_status_t status;
    apq_task_t   served_task_id;
    apq_prio_t   served_priority;
  } apq_result_t;

  // One stored slot as it sits in the slot memory.
  typedef struct packed {
    apq_prio_t prio;
    apq_task_t task_id;
  } apq_slot_t;

endpackage

FILE: sv/apq_if.sv
// Valid/ready channel interfaces for requests and responses.
interface apq_req_if import apq_pkg::*; ();
  logic      valid;
  logic      ready;
  logic      req_type;
  apq_prio_t push_priority;
  apq_task_t push_task_id;

  modport source (output valid, output req_type, output push_priority,
                  output push_task_id, input ready);
  modport sink (input valid, input req_type, input push_priority,
                input push_task_id, output ready);
endinterface

interface apq_rsp_if import apq_pkg::*; ();
  logic        valid;
  logic        ready;
  apq_status_t status;
  apq_task_t   served_task_id;
  apq_prio_t   served_priority;

  modport source (output valid, output status, output served_task_id,
                  output served_priority, input ready);
  modport sink (input valid, input status, input served_task_id,
                input served_priority, output ready);
endinterface

FILE: sv/apq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module apq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/aging_priority_queue_core.sv
// Top level of the aging priority queue: sequencer, slot scan unit and output register.
//
//   Channel   Dir  Beat contents                                   Handshake
//   in_req    in   req_type, push_priority, push_task_id           valid/ready
//   out_rsp   out  status, served_task_id, served_priority         valid/ready
//
// A push scans the valid bits one slot per cycle from slot 0 and writes the first
// free slot; if no slot is free it answers full.
// A pop on a non-empty store streams every slot through the one compare and
// increment unit behind the slot memory's registered read port.
// A pop on an empty store answers empty without a scan.
// Reset is synchronous and active low; it clears all valid bits and the control
// state. The slot memory is not cleared, since data of invalid slots is never used.
// The request side is ready only while the sequencer is idle. The response sits in
// its own register, so a new request is taken while a response still waits; the
// sequencer holds a finished result until that register frees up.
`include "aging_priority_queue_core_defines.svh"

module aging_priority_queue_core import apq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  apq_req_if.sink    in_req,
  apq_rsp_if.source  out_rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUSH = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state_r;
  logic [DEPTH-1:0] valid_r;
  apq_item_t        item_r;

  // Scan counters: scan_idx_r is the slot being looked at (push) or the read
  // address being issued (pop). pend_* tracks the slot whose data comes back.
  logic [IDX_W-1:0] scan_idx_r;
  logic             issue_r;
  logic             pend_vld_r;
  logic [IDX_W-1:0] pend_idx_r;

  // Running maximum of the pop scan.
  logic             best_found_r;
  logic             best_found_nxt;
  logic [IDX_W-1:0] best_idx_r;
  logic [IDX_W-1:0] best_idx_nxt;
  apq_prio_t        best_prio_r;
  apq_prio_t        best_prio_nxt;
  apq_task_t        best_task_r;
  apq_task_t        best_task_nxt;

  apq_result_t res_r;
  apq_result_t out_res_r;
  logic        out_valid_r;

  // Slot memory ports.
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  apq_slot_t        ram_wr_data;
  logic             ram_rd_en;
  apq_slot_t        ram_rd_data;

  logic      in_fire;
  logic      out_free;
  logic      slot_live;
  logic      take;
  logic      scan_end;
  apq_prio_t aged_prio;

  apq_ram #(
    .WIDTH ($bits(apq_slot_t)),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (scan_idx_r),
    .rd_data (ram_rd_data)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  // Shared compare and increment unit, fed by the slot returning from memory.
  assign slot_live = pend_vld_r && valid_r[pend_idx_r];
  assign take      = slot_live && (!best_found_r || (ram_rd_data.prio > best_prio_r));
  assign aged_prio = (ram_rd_data.prio == PRIO_MAX) ? ram_rd_data.prio
                                                    : ram_rd_data.prio + PRIO_W'(1);
  assign scan_end  = pend_vld_r && (pend_idx_r == LAST_IDX);

  always_comb begin
    best_found_nxt = best_found_r || take;
    best_idx_nxt   = take ? pend_idx_r : best_idx_r;
    best_prio_nxt  = take ? ram_rd_data.prio : best_prio_r;
    best_task_nxt  = take ? ram_rd_data.task_id : best_task_r;
  end

  // The pop scan ages every live slot as it passes; the winner is aged too, but
  // its valid bit drops at the end of the scan, so that write never matters.
  always_comb begin
    ram_rd_en   = (state_r == S_POP) && issue_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = scan_idx_r;
    ram_wr_data = '{prio: item_r.push_priority, task_id: item_r.push_task_id};
    if (state_r == S_PUSH) begin
      ram_wr_en = !valid_r[scan_idx_r];
    end else if (state_r == S_POP) begin
      ram_wr_en   = slot_live;
      ram_wr_addr = pend_idx_r;
      ram_wr_data = '{prio: aged_prio, task_id: ram_rd_data.task_id};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      issue_r      <= 1'b0;
      pend_vld_r   <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            item_r       <= '{req_type: in_req.req_type,
                              push_priority: in_req.push_priority,
                              push_task_id: in_req.push_task_id};
            scan_idx_r   <= '0;
            pend_vld_r   <= 1'b0;
            best_found_r <= 1'b0;
            if (in_req.req_type == REQ_PUSH) begin
              state_r <= S_PUSH;
            end else if (valid_r == '0) begin
              res_r   <= '{status: ST_EMPTY, served_task_id: '0, served_priority: '0};
              state_r <= S_FIN;
            end else begin
              issue_r <= 1'b1;
              state_r <= S_POP;
            end
          end
        end
        S_PUSH: begin
          if (!valid_r[scan_idx_r]) begin
            valid_r[scan_idx_r] <= 1'b1;
            res_r   <= '{status: ST_DONE, served_task_id: '0, served_priority: '0};
            state_r <= S_FIN;
          end else if (scan_idx_r == LAST_IDX) begin
            res_r   <= '{status: ST_FULL, served_task_id: '0, served_priority: '0};
            state_r <= S_FIN;
          end else begin
            scan_idx_r <= scan_idx_r + IDX_W'(1);
          end
        end
        S_POP: begin
          pend_vld_r <= issue_r;
          pend_idx_r <= scan_idx_r;
          if (issue_r) begin
            if (scan_idx_r == LAST_IDX) begin
              issue_r <= 1'b0;
            end else begin
              scan_idx_r <= scan_idx_r + IDX_W'(1);
            end
          end
          best_found_r <= best_found_nxt;
          best_idx_r   <= best_idx_nxt;
          best_prio_r  <= best_prio_nxt;
          best_task_r  <= best_task_nxt;
          if (scan_end) begin
            pend_vld_r             <= 1'b0;
            valid_r[best_idx_nxt]  <= 1'b0;
            res_r   <= '{status: ST_DONE, served_task_id: best_task_nxt,
                         served_priority: best_prio_nxt};
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Response payload register, loaded when a finished result moves out.
  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && out_free) begin
      out_res_r <= res_r;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.status          = out_res_r.status;
  assign out_rsp.served_task_id  = out_res_r.served_task_id;
  assign out_rsp.served_priority = out_res_r.served_priority;

  // An accepted request always starts work.
  `APQ_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_fire, state_r != S_IDLE,
                   "request accepted but sequencer idle")
  // A successful push fills exactly one slot.
  `APQ_ASSERT_NEXT(a_push_fills_one, clk, rst_n, (state_r == S_PUSH) && !valid_r[scan_idx_r],
                   $countones(valid_r) == $past($countones(valid_r)) + 1,
                   "push did not fill exactly one slot")
  // The end of a pop scan frees exactly one slot.
  `APQ_ASSERT_NEXT(a_pop_frees_one, clk, rst_n, (state_r == S_POP) && scan_end,
                   $countones(valid_r) == $past($countones(valid_r)) - 1,
                   "pop did not free exactly one slot")
  // A pop scan only starts on a non-empty store, so it always finds a winner.
  `APQ_ASSERT_NOW(a_pop_has_winner, clk, rst_n, (state_r == S_POP) && scan_end,
                  best_found_nxt, "pop scan ended without a winner")
  // Refused or empty responses carry no task.
  `APQ_ASSERT_NOW(a_no_task_on_fail, clk, rst_n, out_valid_r && (out_res_r.status != ST_DONE),
                  (out_res_r.served_task_id == '0) && (out_res_r.served_priority == '0),
                  "failed response carries task data")

endmodule
